// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ----- rtl/core/hfs_pkg.sv -----
// shared types, constants and table builders for the frequency shifter
package hfs_pkg;

   localparam int TAP_W = 18;
   localparam int SIN_W = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [8:0]  MIX_FULL   = 9'd256;
   localparam logic [8:0]  MIX_RESET  = 9'd128;
   localparam logic [15:0] GAIN_RESET = 16'd4096;

   localparam logic [63:0] Q30_ONE    = 64'd1073741824;
   localparam logic [63:0] PI_Q30     = 64'd3373259426;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYPASS      = 8'd0,
      CSR_PHASE_STEP  = 8'd1,
      CSR_MIX_LEVEL   = 8'd2,
      CSR_OUTPUT_GAIN = 8'd3
   } csr_index_type;

   typedef enum logic {
      KIND_SHIFT = 1'b0,
      KIND_PASS  = 1'b1
   } kind_type;

   typedef struct packed {
      logic        bypass;
      logic [31:0] phase_step;
      logic [8:0]  mix_level;
      logic [15:0] output_gain;
   } cfg_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
      logic       empty;
   } queue_status_type;

   typedef struct packed {
      logic idle;
   } back_status_type;

   // elaboration-time restoring divide
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // sign and q30 magnitude of sin(2*pi*turn/2^32)
   function automatic logic [32:0] sin_mag(input logic [31:0] turn);
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] r;
      frac = 64'(turn[29:0]);
      if (turn[30]) frac = Q30_ONE - frac;
      x = (frac * TWO_PI_Q30) >> 32;
      x2 = (x * x) >> 30;
      t = Q30_ONE;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      r = (x * t) >> 30;
      return {turn[31], r[31:0]};
   endfunction

   function automatic logic signed [SIN_W-1:0] sine_entry(input int k, input int bits);
      logic [31:0] turn;
      logic [32:0] sm;
      logic [63:0] v;
      turn = 32'(64'(k) << (32 - bits));
      sm = sin_mag(turn);
      v = (64'(sm[31:0]) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return sm[32] ? -SIN_W'(v) : SIN_W'(v);
   endfunction

   // hann-windowed hilbert tap, q1.17
   function automatic logic signed [TAP_W-1:0] tap_entry(input int i, input int taps);
      logic [63:0] turn;
      logic [63:0] s;
      logic [63:0] w;
      logic [63:0] den;
      logic [63:0] v;
      logic [32:0] sm;
      int n;
      int an;
      n = i - (taps >> 1);
      an = (n < 0) ? -n : n;
      if (an[0] == 1'b0) return '0;
      turn = udiv((64'(i) << 31) + 64'((taps - 1) >> 1), 64'(taps - 1));
      sm = sin_mag(turn[31:0]);
      s = 64'(sm[31:0]);
      w = (s * s) >> 30;
      den = PI_Q30 * 64'(an);
      v = udiv((w << 18) + (den >> 1), den);
      return (n < 0) ? -TAP_W'(v) : TAP_W'(v);
   endfunction

endpackage

// ----- rtl/core/hfs_front.sv -----
// input stage: takes a transaction and tags it as shift or pass-through
module hfs_front import hfs_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          bypass,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [2*SAMPLE_BITS:0]        out_data
);

   logic                   hold_v_ff;
   logic [2*SAMPLE_BITS:0] hold_ff;
   kind_type               kind;

   assign kind = bypass ? KIND_PASS : KIND_SHIFT;
   assign req_ready = !hold_v_ff || out_ready;
   assign out_valid = hold_v_ff;
   assign out_data = hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else if (req_ready) begin
         hold_v_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         hold_ff <= {kind, req_left_in, req_right_in};
      end
   end

endmodule

// ----- rtl/core/hfs_queue.sv -----
// two-entry queue between the input stage and the engine
module hfs_queue import hfs_pkg::*; #(
   parameter int W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [W-1:0]     in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [W-1:0]     out_data,
   output queue_status_type status
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ff;
   logic         rd_ff;
   logic [1:0]   cnt_ff;
   logic         push;
   logic         pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_pop && out_valid;
   assign status = '{count: cnt_ff, full: !in_ready, empty: !out_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end

endmodule

// ----- rtl/core/hfs_back.sv -----
// engine: hilbert fir, quadrature oscillator, mix, gain and saturation
module hfs_back import hfs_pkg::*; #(
   parameter int TAPS            = 63,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          q_valid,
   input  logic [2*SAMPLE_BITS:0]        q_data,
   output logic                          q_pop,
   output back_status_type               status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out
);

   localparam int SB    = SAMPLE_BITS;
   localparam int STB   = SINE_TABLE_BITS;
   localparam int TBL   = 1 << STB;
   localparam int PW    = $clog2(TAPS);
   localparam int CW    = $clog2(TAPS + 1);
   localparam int HALF  = TAPS / 2;
   localparam int PROD_W = TAP_W + SB;
   localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
   localparam int IM_W  = ACC_W - 17;
   localparam int PA_W  = SB + SIN_W;
   localparam int PB_W  = IM_W + SIN_W;
   localparam int WET_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
   localparam int T1_W  = SB + 10;
   localparam int T2_W  = WET_W + 10;
   localparam int SUM_W = (((T1_W + 15) > T2_W) ? (T1_W + 15) : T2_W) + 2;
   localparam int MX_W  = SUM_W - 23;
   localparam int GP_W  = MX_W + 17;
   localparam int V_W   = GP_W - 11;

   localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << 16;
   localparam logic signed [SUM_W-1:0] SUM_RND = SUM_W'(1) << 22;
   localparam logic signed [GP_W:0]    GP_RND  = (GP_W + 1)'(1) << 11;
   localparam logic signed [V_W-1:0]   SAT_HI  = V_W'((1 << (SB - 1)) - 1);
   localparam logic signed [V_W-1:0]   SAT_LO  = -SAT_HI - V_W'(1);
   localparam logic [STB-1:0]          QTR     = {2'b01, {(STB - 2){1'b0}}};

   typedef logic signed [SIN_W-1:0] sine_rom_type [TBL];
   typedef logic signed [TAP_W-1:0] tap_rom_type [TAPS];

   function automatic sine_rom_type build_sine();
      sine_rom_type r;
      for (int k = 0; k < TBL; k++) r[k] = sine_entry(k, STB);
      return r;
   endfunction

   function automatic tap_rom_type build_taps();
      tap_rom_type r;
      for (int i = 0; i < TAPS; i++) r[i] = tap_entry(i, TAPS);
      return r;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();
   localparam tap_rom_type  TAP_ROM  = build_taps();

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_COS, ST_MAC, ST_DRAIN, ST_IM, ST_PROD,
      ST_WET, ST_SCALE, ST_MIXED, ST_GAIN, ST_DONE
   } state_type;

   state_type state_ff;

   // history memories, one per channel
   logic signed [SB-1:0] hist_l [TAPS];
   logic signed [SB-1:0] hist_r [TAPS];
   logic signed [SB-1:0] hl_q_ff;
   logic signed [SB-1:0] hr_q_ff;
   logic signed [SIN_W-1:0] rom_q_ff;

   kind_type             kind_ff;
   logic signed [SB-1:0] smp_ff [2];
   logic [31:0]          phase_ff;
   logic [STB-1:0]       idx_ff;
   logic [STB-1:0]       rom_addr;
   logic [PW-1:0]        wp_ff;
   logic [PW-1:0]        wp_in;
   logic [PW-1:0]        rd_ff;
   logic [PW-1:0]        k_ff;
   logic [CW-1:0]        fill_ff;
   logic signed [SIN_W-1:0] sin_ff;
   logic signed [SIN_W-1:0] cos_ff;

   logic                    s1_v_ff;
   logic                    s2_v_ff;
   logic [PW-1:0]           s1_k_ff;
   logic                    s1_ok_ff;
   logic signed [TAP_W-1:0] tap_q_ff;

   logic signed [SB-1:0]     h_m   [2];
   logic signed [PROD_W-1:0] p_ff  [2];
   logic signed [ACC_W-1:0]  acc_ff [2];
   logic signed [ACC_W-1:0]  acc_r [2];
   logic signed [SB-1:0]     dry_ff [2];
   logic signed [IM_W-1:0]   im_ff [2];
   logic signed [PA_W-1:0]   pa_ff [2];
   logic signed [PB_W-1:0]   pb_ff [2];
   logic signed [WET_W-1:0]  wet_ff [2];
   logic signed [T1_W-1:0]   t1_ff [2];
   logic signed [T2_W-1:0]   t2_ff [2];
   logic signed [SUM_W-1:0]  sum_w [2];
   logic signed [MX_W-1:0]   mx_ff [2];
   logic signed [GP_W-1:0]   gp_ff [2];
   logic signed [GP_W:0]     gr_w [2];
   logic signed [V_W-1:0]    v_w [2];
   logic signed [SB-1:0]     sat_w [2];

   logic [8:0]        m9;
   logic [8:0]        dm9;
   logic signed [9:0] wm;
   logic signed [9:0] dm;
   logic signed [16:0] gain_s;

   logic                 rsp_valid_ff;
   logic signed [SB-1:0] rsp_left_ff;
   logic signed [SB-1:0] rsp_right_ff;

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign status = '{idle: (state_ff == ST_IDLE)};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_out = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   assign wp_in = (wp_ff == PW'(TAPS - 1)) ? '0 : wp_ff + PW'(1);
   assign rom_addr = (state_ff == ST_START) ? phase_ff[31 -: STB] : idx_ff + QTR;

   assign m9 = (cfg.mix_level > MIX_FULL) ? MIX_FULL : cfg.mix_level;
   assign dm9 = MIX_FULL - m9;
   assign wm = $signed({1'b0, m9});
   assign dm = $signed({1'b0, dm9});
   assign gain_s = $signed({1'b0, cfg.output_gain});

   always_comb begin
      h_m[0] = s1_ok_ff ? hl_q_ff : '0;
      h_m[1] = s1_ok_ff ? hr_q_ff : '0;
      for (int l = 0; l < 2; l++) begin
         acc_r[l] = acc_ff[l] + ACC_RND;
         sum_w[l] = (SUM_W'(t1_ff[l]) <<< 15) + SUM_W'(t2_ff[l]) + SUM_RND;
         gr_w[l] = (GP_W + 1)'(gp_ff[l]) + GP_RND;
         v_w[l] = gr_w[l][GP_W:12];
         if (v_w[l] > SAT_HI) sat_w[l] = SB'(SAT_HI);
         else if (v_w[l] < SAT_LO) sat_w[l] = SB'(SAT_LO);
         else sat_w[l] = SB'(v_w[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_START) begin
         hist_l[wp_in] <= smp_ff[0];
         hist_r[wp_in] <= smp_ff[1];
      end
      hl_q_ff <= hist_l[rd_ff];
      hr_q_ff <= hist_r[rd_ff];
      rom_q_ff <= SINE_ROM[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         phase_ff <= '0;
         wp_ff <= '0;
         fill_ff <= '0;
      end else begin
         s1_v_ff <= (state_ff == ST_MAC);
         s2_v_ff <= s1_v_ff;
         // the done state decides the valid flag on its own
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  kind_ff <= kind_type'(q_data[2*SB]);
                  smp_ff[0] <= q_data[2*SB-1:SB];
                  smp_ff[1] <= q_data[SB-1:0];
                  state_ff <= (kind_type'(q_data[2*SB]) == KIND_PASS) ? ST_DONE : ST_START;
               end
            end
            ST_START: begin
               idx_ff <= phase_ff[31 -: STB];
               phase_ff <= phase_ff + cfg.phase_step;
               wp_ff <= wp_in;
               rd_ff <= wp_in;
               if (fill_ff != CW'(TAPS)) fill_ff <= fill_ff + CW'(1);
               k_ff <= '0;
               state_ff <= ST_COS;
            end
            ST_COS: begin
               sin_ff <= rom_q_ff;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (k_ff == '0) cos_ff <= rom_q_ff;
               rd_ff <= (rd_ff == '0) ? PW'(TAPS - 1) : rd_ff - PW'(1);
               k_ff <= k_ff + PW'(1);
               if (k_ff == PW'(TAPS - 1)) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (!s1_v_ff && !s2_v_ff) state_ff <= ST_IM;
            end
            ST_IM: begin
               for (int l = 0; l < 2; l++) im_ff[l] <= acc_r[l][ACC_W-1:17];
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               for (int l = 0; l < 2; l++) begin
                  pa_ff[l] <= PA_W'(dry_ff[l]) * PA_W'(cos_ff);
                  pb_ff[l] <= PB_W'(im_ff[l]) * PB_W'(sin_ff);
               end
               state_ff <= ST_WET;
            end
            ST_WET: begin
               for (int l = 0; l < 2; l++) wet_ff[l] <= WET_W'(pa_ff[l]) - WET_W'(pb_ff[l]);
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               for (int l = 0; l < 2; l++) begin
                  t1_ff[l] <= T1_W'(dry_ff[l]) * T1_W'(dm);
                  t2_ff[l] <= T2_W'(wet_ff[l]) * T2_W'(wm);
               end
               state_ff <= ST_MIXED;
            end
            ST_MIXED: begin
               for (int l = 0; l < 2; l++) mx_ff[l] <= sum_w[l][SUM_W-1:23];
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               for (int l = 0; l < 2; l++) gp_ff[l] <= GP_W'(mx_ff[l]) * GP_W'(gain_s);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff <= (kind_ff == KIND_PASS) ? smp_ff[0] : sat_w[0];
                  rsp_right_ff <= (kind_ff == KIND_PASS) ? smp_ff[1] : sat_w[1];
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      // tap pipeline: read, multiply, accumulate
      tap_q_ff <= TAP_ROM[k_ff];
      s1_k_ff <= k_ff;
      s1_ok_ff <= (CW'(k_ff) < fill_ff);
      for (int l = 0; l < 2; l++) begin
         p_ff[l] <= PROD_W'(tap_q_ff) * PROD_W'(h_m[l]);
         if (s1_v_ff && s1_k_ff == PW'(HALF)) dry_ff[l] <= h_m[l];
         if (state_ff == ST_START) acc_ff[l] <= '0;
         else if (s2_v_ff) acc_ff[l] <= acc_ff[l] + ACC_W'(p_ff[l]);
      end
   end

endmodule

// ----- rtl/core/hilbert_frequency_shifter_top.sv -----
// top level of the stereo hilbert frequency shifter
// Stereo single-sideband frequency shifter. Each req transaction carries one
// left/right sample pair and yields exactly one rsp transaction. For a shifted
// sample in the engine, the Hilbert FIR walks the history one tap per cycle
// through a single read port of each channel's history memory, followed by a
// short chain of multiply stages for the oscillator, mix and gain. In bypass
// filter history and phase stay frozen. A two-entry queue plus an input
// register let up to three requests wait while the engine works or while a
// result waits for rsp_ready. The csr port is always ready; write it only
// while the block is idle. Register indexes: 0 bypass, 1 phase_step,
// 2 mix_level (Q0.8, values above 256 act as 256), 3 output_gain (Q4.12);
// other indexes are ignored. No clearing pass is needed after reset: history
// entries not yet written read as zero.
`include "assert_macros.svh"
module hilbert_frequency_shifter_top import hfs_pkg::*; #(
   parameter int TAPS            = 63,
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int QW = 2 * SAMPLE_BITS + 1;

   cfg_type          cfg_ff;
   logic             f_valid;
   logic             f_ready;
   logic [QW-1:0]    f_data;
   logic             q_valid;
   logic             q_pop;
   logic [QW-1:0]    q_data;
   queue_status_type q_status;
   back_status_type  back_status;

   // configuration registers, written one transaction at a time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{bypass: 1'b0, phase_step: '0, mix_level: MIX_RESET,
                     output_gain: GAIN_RESET};
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BYPASS:      cfg_ff.bypass <= csr_data[0];
            CSR_PHASE_STEP:  cfg_ff.phase_step <= csr_data[31:0];
            CSR_MIX_LEVEL:   cfg_ff.mix_level <= csr_data[8:0];
            CSR_OUTPUT_GAIN: cfg_ff.output_gain <= csr_data[15:0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   // front: accept and tag
   hfs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset), .bypass(cfg_ff.bypass),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_in(req_left_in), .req_right_in(req_right_in),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   // decoupling queue
   hfs_queue #(.W(QW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_pop(q_pop), .out_data(q_data),
      .status(q_status)
   );

   // back: fir, oscillator, mix, gain
   hfs_back #(
      .TAPS(TAPS), .SINE_TABLE_BITS(SINE_TABLE_BITS), .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .status(back_status),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_left_out(rsp_left_out), .rsp_right_out(rsp_right_out)
   );

   // queue never holds more than its two entries
   `ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1, q_status.count != 2'd3)
   // a waiting queue entry is picked up by an idle engine at once
   `ASSERT_NEXT(a_engine_takes, clock, reset, back_status.idle && !q_status.empty, !back_status.idle)
   // the front never pushes into a full queue
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, q_status.full && !q_pop, !f_ready)

endmodule
